### hdl/tcms_pkg.sv
// ----------------------------------------------------------------------------
// tcms_pkg: shared types and constants of the two-class message scheduler.
// Holds the default sizes, the key width, the controller states and the
// command and status structs that pass between controller and datapath.
// ----------------------------------------------------------------------------
package tcms_pkg;

	localparam int PlainDepthDef  = 16;
	localparam int SortedDepthDef = 16;
	localparam int HandleBitsDef  = 16;
	localparam int FieldBits      = 16;
	localparam int KeyBits        = 33;
	localparam int TotalBits      = 6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH_PLAIN,
		OP_PUSH_SORTED,
		OP_POP
	} op_t;

	typedef struct packed {
		logic capture;
		op_t  op;
	} dp_cmd_t;

	typedef struct packed {
		logic pop_req;
		logic is_request;
	} dp_status_t;

endpackage

### hdl/tcms_ctrl.sv
// ----------------------------------------------------------------------------
// tcms_ctrl: controller of the scheduler.
// Accepts one item, has the datapath execute it, then holds the result until
// the receiver takes it.
// ----------------------------------------------------------------------------
module tcms_ctrl
	import tcms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_EXEC;
			end
			ST_EXEC: state_next = ST_OUT;
			ST_OUT: begin
				if (out_ready) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.capture = 1'b0;
		cmd.op      = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				if (status.pop_req) cmd.op = OP_POP;
				else if (status.is_request) cmd.op = OP_PUSH_SORTED;
				else cmd.op = OP_PUSH_PLAIN;
			end
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

### hdl/tcms_dp.sv
// ----------------------------------------------------------------------------
// tcms_dp: datapath of the scheduler.
// A shift FIFO for plain messages and a sorted cell chain for requests, with
// the key subtractor and the result registers.
// ----------------------------------------------------------------------------
module tcms_dp
	import tcms_pkg::*;
#(
	parameter int PLAIN_DEPTH  = PlainDepthDef,
	parameter int SORTED_DEPTH = SortedDepthDef,
	parameter int HANDLE_BITS  = HandleBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	input  logic                 req_type,
	input  logic                 is_request,
	input  logic [FieldBits-1:0] msg_handle,
	input  logic [FieldBits-1:0] want_cycle,
	input  logic [FieldBits-1:0] want_pos,
	input  logic [FieldBits-1:0] tip_cycle,
	input  logic [FieldBits-1:0] tip_pos,
	output logic                 got_message,
	output logic [FieldBits-1:0] out_handle,
	output logic                 from_request_store,
	output logic                 push_dropped,
	output logic [TotalBits-1:0] total_held
);

	localparam int PcBits = $clog2(PLAIN_DEPTH + 1);
	localparam int ScBits = $clog2(SORTED_DEPTH + 1);
	localparam int SumBits = (PcBits > ScBits ? PcBits : ScBits) + 1;

	logic                       pop_q, isreq_q;
	logic [HANDLE_BITS-1:0]     hnd_q;
	logic signed [KeyBits-1:0]  key_q;
	logic [HANDLE_BITS-1:0]     plain_q [PLAIN_DEPTH];
	logic [HANDLE_BITS-1:0]     shand_q [SORTED_DEPTH];
	logic signed [KeyBits-1:0]  skey_q  [SORTED_DEPTH];
	logic [PcBits-1:0]          pcnt_q;
	logic [ScBits-1:0]          scnt_q;
	logic [SORTED_DEPTH-1:0]    gt;
	logic [HANDLE_BITS-1:0]     h_in;
	logic [SumBits-1:0]         sum;
	logic [PcBits-1:0]          pcnt_n;
	logic [ScBits-1:0]          scnt_n;

	assign status.pop_req    = pop_q;
	assign status.is_request = isreq_q;

	assign h_in = HANDLE_BITS'(msg_handle);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pop_q   <= req_type;
			isreq_q <= is_request;
			hnd_q   <= h_in;
			key_q   <= $signed({1'b0, want_cycle, want_pos})
				- $signed({1'b0, tip_cycle, tip_pos});
		end
	end

	always_comb begin
		for (int i = 0; i < SORTED_DEPTH; i++) begin
			gt[i] = (i < int'(scnt_q)) && (skey_q[i] > key_q);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_PUSH_PLAIN: begin
				if (int'(pcnt_q) < PLAIN_DEPTH) begin
					plain_q[pcnt_q[$clog2(PLAIN_DEPTH)-1:0]] <= hnd_q;
				end
			end
			OP_PUSH_SORTED: begin
				if (int'(scnt_q) < SORTED_DEPTH) begin
					for (int i = 0; i < SORTED_DEPTH; i++) begin
						if (gt[i]) begin
							if (i > 0 && gt[i-1]) begin
								skey_q[i]  <= skey_q[i-1];
								shand_q[i] <= shand_q[i-1];
							end else begin
								skey_q[i]  <= key_q;
								shand_q[i] <= hnd_q;
							end
						end else if (i == int'(scnt_q)) begin
							if (i > 0 && gt[i-1]) begin
								skey_q[i]  <= skey_q[i-1];
								shand_q[i] <= shand_q[i-1];
							end else begin
								skey_q[i]  <= key_q;
								shand_q[i] <= hnd_q;
							end
						end
					end
				end
			end
			OP_POP: begin
				if (pcnt_q != '0) begin
					for (int i = 0; i < PLAIN_DEPTH - 1; i++) plain_q[i] <= plain_q[i+1];
				end else if (scnt_q != '0) begin
					for (int i = 0; i < SORTED_DEPTH - 1; i++) begin
						skey_q[i]  <= skey_q[i+1];
						shand_q[i] <= shand_q[i+1];
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		pcnt_n = pcnt_q;
		scnt_n = scnt_q;
		unique case (cmd.op)
			OP_PUSH_PLAIN:  if (int'(pcnt_q) < PLAIN_DEPTH) pcnt_n = pcnt_q + 1'b1;
			OP_PUSH_SORTED: if (int'(scnt_q) < SORTED_DEPTH) scnt_n = scnt_q + 1'b1;
			OP_POP: begin
				if (pcnt_q != '0) pcnt_n = pcnt_q - 1'b1;
				else if (scnt_q != '0) scnt_n = scnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	assign sum = SumBits'(pcnt_n) + SumBits'(scnt_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= '0;
			scnt_q <= '0;
		end else begin
			pcnt_q <= pcnt_n;
			scnt_q <= scnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op != OP_NONE) begin
			got_message        <= 1'b0;
			out_handle         <= '0;
			from_request_store <= 1'b0;
			push_dropped       <= 1'b0;
			total_held         <= TotalBits'(sum);
			unique case (cmd.op)
				OP_PUSH_PLAIN:  push_dropped <= (int'(pcnt_q) >= PLAIN_DEPTH);
				OP_PUSH_SORTED: push_dropped <= (int'(scnt_q) >= SORTED_DEPTH);
				OP_POP: begin
					if (pcnt_q != '0) begin
						got_message <= 1'b1;
						out_handle  <= FieldBits'(plain_q[0]);
					end else if (scnt_q != '0) begin
						got_message        <= 1'b1;
						from_request_store <= 1'b1;
						out_handle         <= FieldBits'(shand_q[0]);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### hdl/two_class_message_scheduler.sv
// ----------------------------------------------------------------------------
// two_class_message_scheduler: strict-priority FIFO ahead of a sorted store.
//
// The input channel carries one push or pop per transfer; the output channel
// returns exactly one result per input transfer. Plain messages leave in
// arrival order and always before requests. Requests leave in order of
// their signed distance ahead of the playback tip, equal keys in arrival
// order. A push into a full store is dropped and flagged.
// An item passes capture with key subtraction, then one update of the
// FIFO or the sorted cell chain that loads the result register in the same
// cycle. The next item is accepted in the cycle after the result transfer,
// so no new item is taken before the last result has been taken. A stalled
// receiver holds the result and blocks the input.
// Reset empties both stores at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module two_class_message_scheduler
	import tcms_pkg::*;
#(
	parameter int PLAIN_DEPTH  = PlainDepthDef,
	parameter int SORTED_DEPTH = SortedDepthDef,
	parameter int HANDLE_BITS  = HandleBitsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 req_type,
	input  logic                 is_request,
	input  logic [FieldBits-1:0] msg_handle,
	input  logic [FieldBits-1:0] want_cycle,
	input  logic [FieldBits-1:0] want_pos,
	input  logic [FieldBits-1:0] tip_cycle,
	input  logic [FieldBits-1:0] tip_pos,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 got_message,
	output logic [FieldBits-1:0] out_handle,
	output logic                 from_request_store,
	output logic                 push_dropped,
	output logic [TotalBits-1:0] total_held
);

	dp_cmd_t    cmd;
	dp_status_t status;

	tcms_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
	);

	tcms_dp #(
		.PLAIN_DEPTH(PLAIN_DEPTH), .SORTED_DEPTH(SORTED_DEPTH), .HANDLE_BITS(HANDLE_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.req_type(req_type), .is_request(is_request), .msg_handle(msg_handle),
		.want_cycle(want_cycle), .want_pos(want_pos), .tip_cycle(tip_cycle),
		.tip_pos(tip_pos), .got_message(got_message), .out_handle(out_handle),
		.from_request_store(from_request_store), .push_dropped(push_dropped),
		.total_held(total_held)
	);

endmodule
